// File: rtl/core/lzbd_pkg.sv
// Shared types and constants for the LZ back-reference decompressor.
// Used by the history RAM and the top-level sequencer; no dependencies.
package lzbd_pkg;

    localparam int WIN_AW    = 12;
    localparam int WIN_DEPTH = 1 << WIN_AW;
    localparam int LEN_W     = 5;
    localparam int COUNT_W   = 32;

    localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;

    typedef logic [7:0]        byte_t;
    typedef logic [WIN_AW-1:0] win_addr_t;

    typedef struct packed {
        logic      en;
        win_addr_t addr;
        byte_t     data;
    } hist_wr_t;

    typedef struct packed {
        logic      en;
        win_addr_t addr;
    } hist_rd_t;

endpackage

// File: rtl/core/lzbd_hist_ram.sv
// History ring for the decompressor: one write port, one registered read port.
// Depends on lzbd_pkg for the address, data and port struct types.
module lzbd_hist_ram
(
    input  logic              clk,
    input  lzbd_pkg::hist_wr_t wr,
    input  lzbd_pkg::hist_rd_t rd,
    output lzbd_pkg::byte_t    rd_data
);

    lzbd_pkg::byte_t mem [lzbd_pkg::WIN_DEPTH];
    lzbd_pkg::byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/lz_backref_decompressor_unit.sv
// LZ back-reference decompressor: a literal item is accepted, then emitted; a back-reference
// of length L (3..18) is accepted, then takes one history RAM read state and one emit/write
// state per byte; an output stall holds the emit state. A literal byte enters the output
// register from the emit state after acceptance, a copied byte from the emit state after its
// read. Reset clears all control state; history slots not yet written read as zero through the
// ring fill tracking, so no clearing pass is needed. Depends on lzbd_pkg and lzbd_hist_ram.
module lz_backref_decompressor_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        is_literal,
    input  logic [7:0]  literal_byte,
    input  logic [7:0]  ref_high,
    input  logic [7:0]  ref_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic        done_res,
    output logic        ref_error
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                          state_reg, state_next;
    lzbd_pkg::win_addr_t                 wp_reg, wp_next;
    logic                                wrapped_reg, wrapped_next;
    logic [lzbd_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [lzbd_pkg::COUNT_W-1:0]        size_reg;
    logic [lzbd_pkg::LEN_W-1:0]          len_reg, len_next;
    lzbd_pkg::win_addr_t                 dm1_reg, dm1_next;
    logic                                err_reg, err_next;
    logic                                lit_reg, lit_next;
    lzbd_pkg::byte_t                     lit_byte_reg, lit_byte_next;
    logic                                hit_reg, hit_next;

    logic                                out_valid_reg, out_valid_next;
    lzbd_pkg::byte_t                     data_byte_reg, data_byte_next;
    logic                                last_reg, last_next;
    logic                                done_reg, done_next;
    logic                                ref_error_reg, ref_error_next;

    logic                                accept;
    logic                                out_free;
    logic                                emit_load;
    lzbd_pkg::win_addr_t                 src_addr;
    logic [lzbd_pkg::COUNT_W-1:0]        count_inc;
    lzbd_pkg::byte_t                     emit_byte;
    lzbd_pkg::byte_t                     rd_data;
    lzbd_pkg::hist_wr_t                  hist_wr;
    lzbd_pkg::hist_rd_t                  hist_rd;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_load = (state_reg == S_EMIT) && out_free;
    assign src_addr  = wp_reg - dm1_reg - lzbd_pkg::win_addr_t'(1);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign emit_byte = lit_reg ? lit_byte_reg : (hit_reg ? rd_data : 8'h00);

    assign hist_rd.en   = (state_reg == S_READ);
    assign hist_rd.addr = src_addr;
    assign hist_wr.en   = emit_load;
    assign hist_wr.addr = wp_reg;
    assign hist_wr.data = emit_byte;

    lzbd_hist_ram u_hist
    (
        .clk     (clk),
        .wr      (hist_wr),
        .rd      (hist_rd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        dm1_next       = dm1_reg;
        err_next       = err_reg;
        lit_next       = lit_reg;
        lit_byte_next  = lit_byte_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_byte_next = data_byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        ref_error_next = ref_error_reg;

        case (state_reg)
            S_IDLE:
            begin
                // drop items that arrive once the size is reached
                if (accept && (count_reg < size_reg))
                begin
                    lit_next      = is_literal;
                    lit_byte_next = literal_byte;
                    dm1_next      = {ref_high[3:0], ref_low};
                    if (is_literal)
                    begin
                        len_next   = lzbd_pkg::LEN_W'(1);
                        err_next   = 1'b0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        len_next   = lzbd_pkg::LEN_W'(ref_high[7:4]) + lzbd_pkg::LEN_BIAS;
                        // distance exceeds count when distance minus one >= count
                        err_next   = (lzbd_pkg::COUNT_W'({ref_high[3:0], ref_low})
                                      >= count_reg);
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // slot holds real data only if the ring has reached it
                hit_next   = wrapped_reg || (src_addr < wp_reg);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_byte_next = emit_byte;
                    last_next      = (len_reg == lzbd_pkg::LEN_W'(1));
                    done_next      = (count_inc >= size_reg);
                    ref_error_next = err_reg;
                    wp_next        = wp_reg + 1'b1;
                    wrapped_next   = wrapped_reg || (wp_reg == '1);
                    count_next     = count_inc;
                    len_next       = len_reg - 1'b1;
                    state_next     = (len_reg == lzbd_pkg::LEN_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            count_reg     <= '0;
            size_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dm1_reg       <= dm1_next;
        err_reg       <= err_next;
        lit_reg       <= lit_next;
        lit_byte_reg  <= lit_byte_next;
        hit_reg       <= hit_next;
        data_byte_reg <= data_byte_next;
        last_reg      <= last_next;
        done_reg      <= done_next;
        ref_error_reg <= ref_error_next;
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign last      = last_reg;
    assign done_res  = done_reg;
    assign ref_error = ref_error_reg;

`ifndef NO_ASSERTIONS
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg >= $past(count_reg)))
        else $error("produced count went backward");

    a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
        hist_wr.en |=> (wp_reg == $past(wp_reg) + 1'b1))
        else $error("write pointer did not advance on history write");

    a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (len_reg != '0))
        else $error("sequencer busy with no bytes left");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && (len_reg == lzbd_pkg::LEN_W'(1))) |=> (state_reg == S_IDLE && last))
        else $error("final byte did not end the item");

    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> out_valid)
        else $error("emitted byte not presented at output");
`endif

endmodule

// File: tb/tb_lz_backref_decompressor_unit.sv
// Self-checking testbench for lz_backref_decompressor_unit: literal and back-reference items
// in, bytes out, each compared with a byte-level model of the history ring and done logic.
// Depends on lzbd_pkg and the decompressor RTL.
module tb_lz_backref_decompressor_unit;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_LEN       = 18;
    localparam int RANDOM_ITEMS  = 340;
    localparam int HOLD_ITEMS    = 24;

    typedef struct {
        logic            is_lit;
        lzbd_pkg::byte_t lit;
        lzbd_pkg::byte_t hi;
        lzbd_pkg::byte_t lo;
    } token_t;

    typedef struct {
        lzbd_pkg::byte_t data;
        logic            last;
        logic            done;
        logic            err;
    } byte_result_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [31:0] cfg_wdata    = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        is_literal   = 1'b0;
    logic [7:0]  literal_byte = '0;
    logic [7:0]  ref_high     = '0;
    logic [7:0]  ref_low      = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  data_byte;
    logic        last;
    logic        done_res;
    logic        ref_error;

    // Model state: history ring, write pointer, byte count and configured size
    lzbd_pkg::byte_t              hist_ring [lzbd_pkg::WIN_DEPTH];
    lzbd_pkg::win_addr_t          ring_wr;
    logic [lzbd_pkg::COUNT_W-1:0] byte_count;
    logic [lzbd_pkg::COUNT_W-1:0] size_reg;
    byte_result_t                 expected_bytes [$];

    int mismatches     = 0;
    int tokens_sent    = 0;
    int ignored_tokens = 0;
    int bytes_checked  = 0;
    int flagged_bytes  = 0;
    int cycle_count    = 0;
    bit tx_quiet       = 1'b0;

    int rx_hold_req  = 0;
    int rx_hold_left = 0;
    int stall_left   = 0;
    int free_left    = 0;

    lz_backref_decompressor_unit i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .is_literal   (is_literal),
        .literal_byte (literal_byte),
        .ref_high     (ref_high),
        .ref_low      (ref_low),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .last         (last),
        .done_res     (done_res),
        .ref_error    (ref_error)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void clear_history();
        foreach (hist_ring[k])
            hist_ring[k] = '0;
        ring_wr    = '0;
        byte_count = '0;
        size_reg   = '0;
    endfunction

    function automatic void push_byte(lzbd_pkg::byte_t b, logic is_last, logic is_err);
        hist_ring[ring_wr] = b;
        ring_wr = ring_wr + 1'b1;
        if (byte_count != '1)
            byte_count = byte_count + 1'b1;
        expected_bytes.push_back('{data: b, last: is_last,
                                   done: (byte_count >= size_reg), err: is_err});
    endfunction

    function automatic void predict_token(token_t t);
        logic [lzbd_pkg::LEN_W-1:0] len;
        logic [12:0]                ref_dist;
        logic                       is_err;
        lzbd_pkg::win_addr_t        src;
        int                         i;
        // drop items once the configured size is reached
        if (byte_count >= size_reg)
        begin
            ignored_tokens++;
            return;
        end
        if (t.is_lit)
        begin
            push_byte(t.lit, 1'b1, 1'b0);
            return;
        end
        len      = lzbd_pkg::LEN_W'(t.hi[7:4]) + lzbd_pkg::LEN_BIAS;
        ref_dist = {1'b0, t.hi[3:0], t.lo} + 13'd1;
        is_err   = lzbd_pkg::COUNT_W'(ref_dist) > byte_count;
        for (i = 0; i < len; i++)
        begin
            // a distance of 4096 wraps onto the slot about to be written
            src = ring_wr - ref_dist[11:0];
            push_byte(hist_ring[src], i == len - 1, is_err);
        end
    endfunction

    function automatic token_t make_literal(lzbd_pkg::byte_t b);
        token_t t;
        t.is_lit = 1'b1;
        t.lit    = b;
        t.hi     = 8'($urandom);
        t.lo     = 8'($urandom);
        return t;
    endfunction

    function automatic token_t make_ref(int len, int ref_dist);
        token_t t;
        t.is_lit = 1'b0;
        t.lit    = 8'($urandom);
        t.hi     = {4'(len - 3), 4'((ref_dist - 1) >> 8)};
        t.lo     = 8'(ref_dist - 1);
        return t;
    endfunction

    function automatic token_t random_token();
        token_t t;
        int     r;
        int     span;
        int     ref_dist;
        int     len;
        r = $urandom_range(0, 99);
        if (r < 25)
            return make_literal(8'($urandom));
        if (r < 85 && byte_count != 0)
        begin
            span = (byte_count > lzbd_pkg::WIN_DEPTH) ? lzbd_pkg::WIN_DEPTH : int'(byte_count);
            if ($urandom_range(0, 2) == 0)
                ref_dist = $urandom_range(1, (span < 8) ? span : 8);
            else
                ref_dist = $urandom_range(1, span);
            len = ($urandom_range(0, 2) != 0) ? MAX_LEN : $urandom_range(3, MAX_LEN);
            return make_ref(len, ref_dist);
        end
        // noise: raw descriptor, may reach before the first byte
        t.is_lit = 1'b0;
        t.lit    = 8'($urandom);
        t.hi     = 8'($urandom);
        t.lo     = 8'($urandom);
        return t;
    endfunction

    // Called at a falling edge; returns at a falling edge after the item is taken.
    task automatic send_token(token_t t);
        int gap;
        in_valid     <= 1'b1;
        is_literal   <= t.is_lit;
        literal_byte <= t.lit;
        ref_high     <= t.hi;
        ref_low      <= t.lo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_token(t);
        tokens_sent++;
        @(negedge clk);
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(logic [lzbd_pkg::COUNT_W-1:0] value);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        size_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_ignore_when_done();
        write_size('0);
        send_token(make_literal(8'h42));
        send_token(make_ref(MAX_LEN, 1));
        send_token(make_literal(8'hBD));
    endtask

    task automatic test_directed_tokens();
        write_size('1);
        // reference before any output reads cleared slots
        send_token(make_ref(3, 1));
        send_token(make_literal(8'h00));
        send_token(make_literal(8'hFF));
        send_token(make_literal(8'hA5));
        send_token(make_literal(8'h5A));
        // overlapping copy repeats the last byte
        send_token(make_ref(MAX_LEN, 1));
        send_token(make_ref(3, 2));
        send_token(make_ref(MAX_LEN, lzbd_pkg::WIN_DEPTH));
        send_token(make_ref(4, int'(byte_count)));
        send_token(make_ref(3, int'(byte_count) + 1));
        send_token(make_literal(8'h80));
        send_token(make_literal(8'h01));
        send_token(make_ref(7, 5));
    endtask

    task automatic test_copy_past_size();
        write_size(byte_count + 2);
        send_token(make_literal(8'h3C));
        // copy runs to its end although done rises on its first byte
        send_token(make_ref(MAX_LEN, 1));
        send_token(make_literal(8'h77));
        send_token(make_ref(5, 2));
        write_size(byte_count + 3);
        send_token(make_literal(8'hC3));
        send_token(make_ref(3, 4));
        send_token(make_literal(8'h11));
    endtask

    task automatic test_random_tokens();
        int n;
        write_size('1);
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            tx_quiet = (n >= 120 && n < 160);
            if (n == 170)
                wait_drain();
            send_token(random_token());
        end
        tx_quiet = 1'b0;
    endtask

    task automatic test_receiver_hold();
        int n;
        rx_hold_req = 400;
        tx_quiet    = 1'b1;
        for (n = 0; n < HOLD_ITEMS; n++)
            send_token(make_ref(MAX_LEN, $urandom_range(1, 64)));
        tx_quiet = 1'b0;
    endtask

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Receiver stall pattern; a requested hold overrides it
    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 39) == 0)
                free_left = $urandom_range(100, 300);
            else
            begin
                stall_left = pick_gap();
                free_left  = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_output
        byte_result_t got;
        byte_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{data: data_byte, last: last, done: done_res, err: ref_error};
            bytes_checked++;
            if (got.err === 1'b1)
                flagged_bytes++;
            if (expected_bytes.size() == 0)
                note_failure($sformatf("byte %02h arrived with nothing expected", got.data));
            else
            begin
                want = expected_bytes.pop_front();
                if (got.data !== want.data || got.last !== want.last ||
                    got.done !== want.done || got.err !== want.err)
                    note_failure($sformatf(
                        "expected data %02h last %b done %b err %b, got %02h %b %b %b",
                        want.data, want.last, want.done, want.err,
                        got.data, got.last, got.done, got.err));
            end
        end
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("timeout with %0d bytes still expected", expected_bytes.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clear_history();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_ignore_when_done();
        test_directed_tokens();
        test_copy_past_size();
        test_random_tokens();
        test_receiver_hold();
        wait_drain();
        $display("items sent %0d (%0d dropped after done), bytes checked %0d",
                 tokens_sent, ignored_tokens, bytes_checked);
        $display("bytes with reference error %0d, final byte count %0d, mismatches %0d",
                 flagged_bytes, byte_count, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
